### sv/pas_pkg.sv
// Shared widths, register indexes and the pipeline item type for the particle step.
package pas_pkg;

  localparam int PW   = 24;
  localparam int VW   = 16;
  localparam int AW   = 12;
  localparam int ZW   = 12;
  localparam int SW   = 20;
  localparam int RLW  = 8;
  localparam int MW   = 25;
  localparam int RW   = MW + 1;
  localparam int NW   = 2 * RW;
  localparam int RMW  = RW + 3;
  localparam int DW   = RW + 2;
  localparam int QW   = 11;
  localparam int CW   = DW + QW;
  localparam int V1W  = 18;

  localparam logic [15:0] DAMP_Q16 = 16'd64881;
  localparam logic [RLW-1:0] RED_BASE = 8'd50;
  localparam logic [RLW-1:0] RED_MAX  = 8'd255;
  localparam logic [ZW-1:0] ZOOM_RESET = 12'd256;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_ATTRACT_X = 2'd1,
    REG_ATTRACT_Y = 2'd2,
    REG_ZOOM      = 2'd3
  } pas_reg_t;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic [MW-1:0]        dxm;
    logic [MW-1:0]        dym;
    logic                 dxn;
    logic                 dyn;
    logic                 pen;
  } pas_item_t;

endpackage

### sv/particle_attractor_step.sv
// Top level of the particle attractor step: config registers and the stage chain.
//
// One particle transaction enters when start is high and busy is low; busy is
// always low, so a new particle may enter on every clock cycle.
// Fields pos_x, pos_y, vel_x, vel_y are sampled at that edge.
// The result appears on the output ports with done high for exactly one cycle,
// in the same order as the particles entered. Throughput is one particle per cycle.
// The pipeline depth comes from the square root (input register plus one result
// bit per stage, 26 stages), the pull divider (one quotient bit per stage) and
// the front and back stages with the multiplies for squares, damping and zoom.
// The receiver cannot hold results off, so nothing ever stalls.
// Configuration: wr_en, wr_index, wr_data write attract_enable, attract_x,
// attract_y, zoom_scale; write only while no particle is in flight.
// Reset (rst, synchronous) empties the pipeline and sets the registers to
// disabled, attractor at 0,0 and zoom 1.0.
module particle_attractor_step #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [pas_pkg::AW-1:0]         wr_data,
  input  logic signed [pas_pkg::PW-1:0]  pos_x,
  input  logic signed [pas_pkg::PW-1:0]  pos_y,
  input  logic signed [pas_pkg::VW-1:0]  vel_x,
  input  logic signed [pas_pkg::VW-1:0]  vel_y,
  output logic                           done,
  output logic signed [pas_pkg::PW-1:0]  new_pos_x,
  output logic signed [pas_pkg::PW-1:0]  new_pos_y,
  output logic signed [pas_pkg::VW-1:0]  new_vel_x,
  output logic signed [pas_pkg::VW-1:0]  new_vel_y,
  output logic [pas_pkg::RLW-1:0]        red_level,
  output logic signed [pas_pkg::SW-1:0]  screen_x,
  output logic signed [pas_pkg::SW-1:0]  screen_y
);

  logic                      attract_enable;
  logic [pas_pkg::AW-1:0]    attract_x, attract_y;
  logic [pas_pkg::ZW-1:0]    zoom_scale;

  logic                      f_valid, s_valid, d_valid;
  pas_pkg::pas_item_t        f_item, s_item, d_item;
  logic [pas_pkg::NW-1:0]    f_n;
  logic [pas_pkg::RW-1:0]    s_root;
  logic [pas_pkg::QW-1:0]    d_qx, d_qy;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attract_enable <= 1'b0;
      attract_x      <= '0;
      attract_y      <= '0;
      zoom_scale     <= pas_pkg::ZOOM_RESET;
    end else if (wr_en) begin
      case (pas_pkg::pas_reg_t'(wr_index))
        pas_pkg::REG_ENABLE:    attract_enable <= wr_data[0];
        pas_pkg::REG_ATTRACT_X: attract_x      <= wr_data;
        pas_pkg::REG_ATTRACT_Y: attract_y      <= wr_data;
        pas_pkg::REG_ZOOM:      zoom_scale     <= wr_data;
        default: begin
        end
      endcase
    end
  end

  pas_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (start && !busy),
    .px             (pos_x),
    .py             (pos_y),
    .vx             (vel_x),
    .vy             (vel_y),
    .attract_enable (attract_enable),
    .attract_x      (attract_x),
    .attract_y      (attract_y),
    .out_valid      (f_valid),
    .out_item       (f_item),
    .out_n          (f_n)
  );

  pas_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_n      (f_n),
    .out_valid (s_valid),
    .out_item  (s_item),
    .out_root  (s_root)
  );

  pas_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_item   (s_item),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_item  (d_item),
    .out_qx    (d_qx),
    .out_qy    (d_qy)
  );

  pas_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_item    (d_item),
    .in_qx      (d_qx),
    .in_qy      (d_qy),
    .zoom_scale (zoom_scale),
    .done       (done),
    .new_pos_x  (new_pos_x),
    .new_pos_y  (new_pos_y),
    .new_vel_x  (new_vel_x),
    .new_vel_y  (new_vel_y),
    .red_level  (red_level),
    .screen_x   (screen_x),
    .screen_y   (screen_y)
  );

endmodule

### sv/pas_front.sv
// Front stages: offset from the attractor, magnitudes, squares and squared distance.
module pas_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [pas_pkg::PW-1:0]  px,
  input  logic signed [pas_pkg::PW-1:0]  py,
  input  logic signed [pas_pkg::VW-1:0]  vx,
  input  logic signed [pas_pkg::VW-1:0]  vy,
  input  logic                           attract_enable,
  input  logic [pas_pkg::AW-1:0]         attract_x,
  input  logic [pas_pkg::AW-1:0]         attract_y,
  output logic                           out_valid,
  output pas_pkg::pas_item_t             out_item,
  output logic [pas_pkg::NW-1:0]         out_n
);

  localparam int MW = pas_pkg::MW;

  logic signed [MW:0] px_ext, py_ext, ax_sh, ay_sh;
  logic               a_valid, a_en;
  logic signed [pas_pkg::PW-1:0] a_px, a_py;
  logic signed [pas_pkg::VW-1:0] a_vx, a_vy;
  logic signed [MW:0] a_dx, a_dy;

  logic               b_valid, c_valid, d_valid;
  pas_pkg::pas_item_t b_item, c_item, d_item;
  logic [2*MW-1:0]    c_sqx, c_sqy;
  logic [pas_pkg::NW-1:0] d_n;

  assign px_ext = (MW+1)'(px);
  assign py_ext = (MW+1)'(py);
  assign ax_sh  = signed'((MW+1)'(attract_x) << FRAC_BITS);
  assign ay_sh  = signed'((MW+1)'(attract_y) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_px <= px;
    a_py <= py;
    a_vx <= vx;
    a_vy <= vy;
    a_en <= attract_enable;
    a_dx <= px_ext - ax_sh;
    a_dy <= py_ext - ay_sh;

    b_item.px  <= a_px;
    b_item.py  <= a_py;
    b_item.vx  <= a_vx;
    b_item.vy  <= a_vy;
    b_item.dxm <= a_dx[MW] ? MW'(-a_dx) : MW'(a_dx);
    b_item.dym <= a_dy[MW] ? MW'(-a_dy) : MW'(a_dy);
    b_item.dxn <= a_dx[MW];
    b_item.dyn <= a_dy[MW];
    b_item.pen <= a_en && ((a_dx != '0) || (a_dy != '0));

    c_item <= b_item;
    c_sqx  <= (2*MW)'(b_item.dxm) * (2*MW)'(b_item.dxm);
    c_sqy  <= (2*MW)'(b_item.dym) * (2*MW)'(b_item.dym);

    d_item <= c_item;
    d_n    <= pas_pkg::NW'(c_sqx) + pas_pkg::NW'(c_sqy);
  end

  assign out_valid = d_valid;
  assign out_item  = d_item;
  assign out_n     = d_n;

endmodule

### sv/pas_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pas_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  pas_pkg::pas_item_t      in_item,
  input  logic [pas_pkg::NW-1:0]  in_n,
  output logic                    out_valid,
  output pas_pkg::pas_item_t      out_item,
  output logic [pas_pkg::RW-1:0]  out_root
);

  localparam int RW  = pas_pkg::RW;
  localparam int NW  = pas_pkg::NW;
  localparam int RMW = pas_pkg::RMW;

  logic               v  [0:RW];
  pas_pkg::pas_item_t it [0:RW];
  logic [NW-1:0]      nn [0:RW];
  logic [RW-1:0]      rt [0:RW];
  logic [RMW-1:0]     rm [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    it[0] <= in_item;
    nn[0] <= in_n;
    rt[0] <= '0;
    rm[0] <= '0;
  end

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RMW-1:0] rem_sh, trial;
    logic           fit;

    assign rem_sh = {rm[i][RMW-3:0], nn[i][NW-1 -: 2]};
    assign trial  = {{(RMW-RW-2){1'b0}}, rt[i], 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      it[i+1] <= it[i];
      nn[i+1] <= {nn[i][NW-3:0], 2'b00};
      rt[i+1] <= {rt[i][RW-2:0], fit};
      rm[i+1] <= fit ? rem_sh - trial : rem_sh;
    end
  end

  assign out_valid = v[RW];
  assign out_item  = it[RW];
  assign out_root  = rt[RW];

endmodule

### sv/pas_div.sv
// Pipelined restoring divider for both pull components, one quotient bit per stage.
module pas_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  pas_pkg::pas_item_t      in_item,
  input  logic [pas_pkg::RW-1:0]  in_root,
  output logic                    out_valid,
  output pas_pkg::pas_item_t      out_item,
  output logic [pas_pkg::QW-1:0]  out_qx,
  output logic [pas_pkg::QW-1:0]  out_qy
);

  localparam int NS = FRAC_BITS - 1;
  localparam int CW = pas_pkg::CW;
  localparam int DW = pas_pkg::DW;
  localparam int QW = pas_pkg::QW;

  logic               v  [0:NS];
  pas_pkg::pas_item_t it [0:NS];
  logic [DW-1:0]      d  [0:NS];
  logic [CW-1:0]      rx [0:NS];
  logic [CW-1:0]      ry [0:NS];
  logic [QW-1:0]      qx [0:NS];
  logic [QW-1:0]      qy [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    it[0] <= in_item;
    d[0]  <= DW'(in_root) + (DW'(in_root) << 1);
    rx[0] <= CW'(in_item.dxm) << FRAC_BITS;
    ry[0] <= CW'(in_item.dym) << FRAC_BITS;
    qx[0] <= '0;
    qy[0] <= '0;
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int K = NS - 1 - j;
    logic [CW-1:0] dsh;
    logic          fx, fy;

    assign dsh = CW'(d[j]) << K;
    assign fx  = rx[j] >= dsh;
    assign fy  = ry[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      it[j+1] <= it[j];
      d[j+1]  <= d[j];
      rx[j+1] <= fx ? rx[j] - dsh : rx[j];
      ry[j+1] <= fy ? ry[j] - dsh : ry[j];
      qx[j+1] <= qx[j] | (QW'(fx) << K);
      qy[j+1] <= qy[j] | (QW'(fy) << K);
    end
  end

  assign out_valid = v[NS];
  assign out_item  = it[NS];
  assign out_qx    = qx[NS];
  assign out_qy    = qy[NS];

endmodule

### sv/pas_back.sv
// Back stages: apply pull, red level, damping, position advance and screen mapping.
module pas_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  pas_pkg::pas_item_t             in_item,
  input  logic [pas_pkg::QW-1:0]         in_qx,
  input  logic [pas_pkg::QW-1:0]         in_qy,
  input  logic [pas_pkg::ZW-1:0]         zoom_scale,
  output logic                           done,
  output logic signed [pas_pkg::PW-1:0]  new_pos_x,
  output logic signed [pas_pkg::PW-1:0]  new_pos_y,
  output logic signed [pas_pkg::VW-1:0]  new_vel_x,
  output logic signed [pas_pkg::VW-1:0]  new_vel_y,
  output logic [pas_pkg::RLW-1:0]        red_level,
  output logic signed [pas_pkg::SW-1:0]  screen_x,
  output logic signed [pas_pkg::SW-1:0]  screen_y
);

  localparam int PW  = pas_pkg::PW;
  localparam int VW  = pas_pkg::VW;
  localparam int V1W = pas_pkg::V1W;
  localparam int SW  = pas_pkg::SW;
  localparam int ZW  = pas_pkg::ZW;
  localparam int PRW = V1W + 16;
  localparam int RSW = V1W + 5;
  localparam int ZPW = PW + ZW;
  localparam int ZSH = FRAC_BITS + 8;

  localparam logic signed [PW:0] P_MAX = (PW+1)'((64'sd1 <<< (PW-1)) - 64'sd1);
  localparam logic signed [PW:0] P_MIN = (PW+1)'(-(64'sd1 <<< (PW-1)));
  localparam logic [PRW-17:0] V_POS_LIM = (PRW-16)'((64'd1 << (VW-1)) - 64'd1);
  localparam logic [PRW-17:0] V_NEG_LIM = (PRW-16)'(64'd1 << (VW-1));
  localparam logic [ZPW-1:0]  S_POS_LIM = ZPW'((64'd1 << (SW-1)) - 64'd1);
  localparam logic [ZPW-1:0]  S_NEG_LIM = ZPW'(64'd1 << (SW-1));
  localparam logic [RSW-1:0]  RED_ROOM  = RSW'(pas_pkg::RED_MAX - pas_pkg::RED_BASE);

  logic [9:1] sv;
  logic signed [PW-1:0] px1, py1, px2, py2, px3, py3, px4, py4, px5, py5;

  logic signed [V1W-1:0] vxe, vye, qxs, qys, v1x, v1y;
  logic [V1W-1:0]        m2x, m2y;
  logic                  n2x, n2y, n3x, n3y;
  logic [PRW-1:0]        p3x, p3y;
  logic [V1W:0]          spd3;
  logic [PRW-17:0]       dmx, dmy;
  logic [RSW-1:0]        scaled;
  logic signed [VW-1:0]  nv4x, nv4y, nv5x, nv5y, nv6x, nv6y, nv7x, nv7y, nv8x, nv8y;
  logic [pas_pkg::RLW-1:0] red4, red5, red6, red7, red8;
  logic signed [VW+1:0]  t5x, t5y;
  logic signed [PW:0]    sum6x, sum6y;
  logic signed [PW-1:0]  np6x, np6y, np7x, np7y, np8x, np8y;
  logic [PW-1:0]         m7x, m7y;
  logic                  n7x, n7y, n8x, n8y;
  logic [ZPW-1:0]        z8x, z8y, s9x, s9y;

  assign vxe = V1W'(in_item.vx);
  assign vye = V1W'(in_item.vy);
  assign qxs = signed'(V1W'(in_qx));
  assign qys = signed'(V1W'(in_qy));
  assign dmx = p3x[PRW-1:16];
  assign dmy = p3y[PRW-1:16];
  assign scaled = ((RSW'(spd3) << 3) + (RSW'(spd3) << 1)) >> FRAC_BITS;
  assign sum6x = (PW+1)'(px5) + (PW+1)'(t5x);
  assign sum6y = (PW+1)'(py5) + (PW+1)'(t5y);
  assign s9x = z8x >> ZSH;
  assign s9y = z8y >> ZSH;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      sv <= {sv[8:1], in_valid};
    end
  end

  assign done = sv[9];

  always_ff @(posedge clk) begin
    px1 <= in_item.px;
    py1 <= in_item.py;
    if (!in_item.pen) begin
      v1x <= vxe;
      v1y <= vye;
    end else begin
      v1x <= in_item.dxn ? vxe + qxs : vxe - qxs;
      v1y <= in_item.dyn ? vye + qys : vye - qys;
    end

    px2 <= px1;
    py2 <= py1;
    m2x <= v1x[V1W-1] ? V1W'(-v1x) : V1W'(v1x);
    m2y <= v1y[V1W-1] ? V1W'(-v1y) : V1W'(v1y);
    n2x <= v1x[V1W-1];
    n2y <= v1y[V1W-1];

    px3  <= px2;
    py3  <= py2;
    p3x  <= PRW'(m2x) * PRW'(pas_pkg::DAMP_Q16);
    p3y  <= PRW'(m2y) * PRW'(pas_pkg::DAMP_Q16);
    n3x  <= n2x;
    n3y  <= n2y;
    spd3 <= (V1W+1)'(m2x) + (V1W+1)'(m2y);

    px4 <= px3;
    py4 <= py3;
    if (n3x) begin
      nv4x <= (dmx >= V_NEG_LIM) ? signed'(VW'(V_NEG_LIM)) : -signed'(VW'(dmx));
    end else begin
      nv4x <= (dmx > V_POS_LIM) ? signed'(VW'(V_POS_LIM)) : signed'(VW'(dmx));
    end
    if (n3y) begin
      nv4y <= (dmy >= V_NEG_LIM) ? signed'(VW'(V_NEG_LIM)) : -signed'(VW'(dmy));
    end else begin
      nv4y <= (dmy > V_POS_LIM) ? signed'(VW'(V_POS_LIM)) : signed'(VW'(dmy));
    end
    red4 <= (scaled > RED_ROOM) ? pas_pkg::RED_MAX
                                : pas_pkg::RED_BASE + scaled[pas_pkg::RLW-1:0];

    px5  <= px4;
    py5  <= py4;
    nv5x <= nv4x;
    nv5y <= nv4y;
    red5 <= red4;
    t5x  <= (VW+2)'(nv4x) + ((VW+2)'(nv4x) <<< 1);
    t5y  <= (VW+2)'(nv4y) + ((VW+2)'(nv4y) <<< 1);

    nv6x <= nv5x;
    nv6y <= nv5y;
    red6 <= red5;
    np6x <= (sum6x > P_MAX) ? PW'(P_MAX) : (sum6x < P_MIN) ? PW'(P_MIN) : PW'(sum6x);
    np6y <= (sum6y > P_MAX) ? PW'(P_MAX) : (sum6y < P_MIN) ? PW'(P_MIN) : PW'(sum6y);

    nv7x <= nv6x;
    nv7y <= nv6y;
    red7 <= red6;
    np7x <= np6x;
    np7y <= np6y;
    m7x  <= np6x[PW-1] ? PW'(-np6x) : PW'(np6x);
    m7y  <= np6y[PW-1] ? PW'(-np6y) : PW'(np6y);
    n7x  <= np6x[PW-1];
    n7y  <= np6y[PW-1];

    nv8x <= nv7x;
    nv8y <= nv7y;
    red8 <= red7;
    np8x <= np7x;
    np8y <= np7y;
    n8x  <= n7x;
    n8y  <= n7y;
    z8x  <= ZPW'(m7x) * ZPW'(zoom_scale);
    z8y  <= ZPW'(m7y) * ZPW'(zoom_scale);

    new_pos_x <= np8x;
    new_pos_y <= np8y;
    new_vel_x <= nv8x;
    new_vel_y <= nv8y;
    red_level <= red8;
    if (n8x) begin
      screen_x <= (s9x >= S_NEG_LIM) ? signed'(SW'(S_NEG_LIM)) : -signed'(SW'(s9x));
    end else begin
      screen_x <= (s9x > S_POS_LIM) ? signed'(SW'(S_POS_LIM)) : signed'(SW'(s9x));
    end
    if (n8y) begin
      screen_y <= (s9y >= S_NEG_LIM) ? signed'(SW'(S_NEG_LIM)) : -signed'(SW'(s9y));
    end else begin
      screen_y <= (s9y > S_POS_LIM) ? signed'(SW'(S_POS_LIM)) : signed'(SW'(s9y));
    end
  end

endmodule

### tb/sv/particle_step_checker.sv
// Checker for the particle attractor step: tracks config, predicts each update, compares.
module particle_step_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [pas_pkg::AW-1:0]         wr_data,
  input  logic signed [pas_pkg::PW-1:0]  pos_x,
  input  logic signed [pas_pkg::PW-1:0]  pos_y,
  input  logic signed [pas_pkg::VW-1:0]  vel_x,
  input  logic signed [pas_pkg::VW-1:0]  vel_y,
  input  logic                           done,
  input  logic signed [pas_pkg::PW-1:0]  new_pos_x,
  input  logic signed [pas_pkg::PW-1:0]  new_pos_y,
  input  logic signed [pas_pkg::VW-1:0]  new_vel_x,
  input  logic signed [pas_pkg::VW-1:0]  new_vel_y,
  input  logic [pas_pkg::RLW-1:0]        red_level,
  input  logic signed [pas_pkg::SW-1:0]  screen_x,
  input  logic signed [pas_pkg::SW-1:0]  screen_y,
  output int                             fail_count,
  output int                             pending
);

  localparam int FB = 8;

  typedef struct packed {
    logic signed [pas_pkg::PW-1:0] px;
    logic signed [pas_pkg::PW-1:0] py;
    logic signed [pas_pkg::VW-1:0] vx;
    logic signed [pas_pkg::VW-1:0] vy;
    logic [pas_pkg::RLW-1:0]       red;
    logic signed [pas_pkg::SW-1:0] sx;
    logic signed [pas_pkg::SW-1:0] sy;
  } particle_out_t;

  particle_out_t expected_updates[$];
  logic          pull_on;
  logic [pas_pkg::AW-1:0] anchor_x, anchor_y;
  logic [pas_pkg::ZW-1:0] zoom;

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 60;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint toward_anchor(longint d, longint r);
    longint q;
    q = (absval(d) << FB) / (3 * r);
    return d < 0 ? -q : q;
  endfunction

  function automatic longint damped(longint v);
    longint m;
    m = (absval(v) * 64881) >> 16;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint zoomed(longint p);
    longint m;
    m = (absval(p) * longint'(zoom)) >> (FB + 8);
    return clamp(p < 0 ? -m : m, pas_pkg::SW);
  endfunction

  function automatic particle_out_t step_particle(longint px, longint py, longint vx, longint vy);
    particle_out_t o;
    longint dx, dy, r, spd, red, nvx, nvy, npx, npy;
    if (pull_on) begin
      dx = px - (longint'(anchor_x) << FB);
      dy = py - (longint'(anchor_y) << FB);
      r = root_floor(dx * dx + dy * dy);
      if (r != 0) begin
        vx -= toward_anchor(dx, r);
        vy -= toward_anchor(dy, r);
      end
    end
    spd = absval(vx) + absval(vy);
    red = 50 + ((10 * spd) >> FB);
    if (red > 255) red = 255;
    nvx = clamp(damped(vx), pas_pkg::VW);
    nvy = clamp(damped(vy), pas_pkg::VW);
    npx = clamp(px + 3 * nvx, pas_pkg::PW);
    npy = clamp(py + 3 * nvy, pas_pkg::PW);
    o.px = pas_pkg::PW'(npx);
    o.py = pas_pkg::PW'(npy);
    o.vx = pas_pkg::VW'(nvx);
    o.vy = pas_pkg::VW'(nvy);
    o.red = pas_pkg::RLW'(red);
    o.sx = pas_pkg::SW'(zoomed(npx));
    o.sy = pas_pkg::SW'(zoomed(npy));
    return o;
  endfunction

  assign pending = expected_updates.size();

  always @(posedge clk) begin
    particle_out_t e;
    if (rst) begin
      pull_on <= 1'b0;
      anchor_x <= '0;
      anchor_y <= '0;
      zoom <= pas_pkg::ZOOM_RESET;
      fail_count <= 0;
      expected_updates.delete();
    end else begin
      if (wr_en) begin
        case (pas_pkg::pas_reg_t'(wr_index))
          pas_pkg::REG_ENABLE: begin
            pull_on <= wr_data[0];
          end
          pas_pkg::REG_ATTRACT_X: begin
            anchor_x <= wr_data;
          end
          pas_pkg::REG_ATTRACT_Y: begin
            anchor_y <= wr_data;
          end
          pas_pkg::REG_ZOOM: begin
            zoom <= wr_data;
          end
          default: ;
        endcase
      end
      if (start && !busy)
        expected_updates = {expected_updates, step_particle(pos_x, pos_y, vel_x, vel_y)};
      if (done) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result new_pos_x=%0d", $time, new_pos_x);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_updates.pop_front();
          if ({new_pos_x, new_pos_y, new_vel_x, new_vel_y, red_level, screen_x, screen_y}
              !== e) begin
            $display("%0t: mismatch expected pos %0d %0d vel %0d %0d red %0d scr %0d %0d",
                     $time, e.px, e.py, e.vx, e.vy, e.red, e.sx, e.sy);
            $display("%0t:          actual pos %0d %0d vel %0d %0d red %0d scr %0d %0d",
                     $time, new_pos_x, new_pos_y, new_vel_x, new_vel_y, red_level,
                     screen_x, screen_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/tb_particle_attractor_step.sv
// Testbench top for the particle attractor step: stimulus, config phases and verdict.
module tb_particle_attractor_step;

  localparam int LATENCY = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PW = pas_pkg::PW;
  localparam int VW = pas_pkg::VW;
  localparam int AW = pas_pkg::AW;

  logic clk, rst, start, busy, wr_en, done;
  logic [1:0] wr_index;
  logic [AW-1:0] wr_data;
  logic signed [PW-1:0] pos_x, pos_y, new_pos_x, new_pos_y;
  logic signed [VW-1:0] vel_x, vel_y, new_vel_x, new_vel_y;
  logic [pas_pkg::RLW-1:0] red_level;
  logic signed [pas_pkg::SW-1:0] screen_x, screen_y;
  int fail_count, pending, idle_cycles;

  particle_attractor_step i_dut (.*);

  particle_step_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(pas_pkg::pas_reg_t idx, logic [AW-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_particle(logic signed [PW-1:0] px, logic signed [PW-1:0] py,
                               logic signed [VW-1:0] vx, logic signed [VW-1:0] vy);
    start <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    vel_x <= vx;
    vel_y <= vy;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(int count, logic [AW-1:0] ax, logic [AW-1:0] ay);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 3))
          0: send_particle(PW'($urandom), PW'($urandom), VW'($urandom), VW'($urandom));
          1: send_particle($signed(PW'(ax) << 8) + PW'($signed(10'($urandom))),
                           $signed(PW'(ay) << 8) + PW'($signed(10'($urandom))),
                           $signed(8'($urandom)), $signed(8'($urandom)));
          2: send_particle((PW'(ax) << 8) + $signed(PW'($urandom_range(0, 4095)) - 2048),
                           (PW'(ay) << 8) + $signed(PW'($urandom_range(0, 4095)) - 2048),
                           $signed(12'($urandom)), $signed(12'($urandom)));
          default: send_particle($signed(PW'($urandom_range(0, 1) ? 24'h7FFF00 : 24'h800100))
                                 + $signed(8'($urandom)), PW'($urandom),
                                 $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                 VW'($urandom));
        endcase
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [AW-1:0] ax, ay;
    rst = 1'b1;
    start = 1'b0;
    wr_en = 1'b0;
    wr_index = pas_pkg::REG_ENABLE;
    wr_data = '0;
    pos_x = '0;
    pos_y = '0;
    vel_x = '0;
    vel_y = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_particle(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000);
    send_particle(24'sh800000, 24'sh7FFFFF, 16'sh8000, 16'sh7FFF);
    send_particle('0, '0, '0, '0);
    send_particle(24'sh000100, -24'sh000100, 16'sh0100, -16'sh0100);
    send_particle(24'shFFFFFF, 24'shFFFFFF, 16'shFFFF, 16'shFFFF);
    start <= 1'b0;
    drain_pipeline();

    write_reg(pas_pkg::REG_ENABLE, 12'd1);
    write_reg(pas_pkg::REG_ATTRACT_X, 12'd100);
    write_reg(pas_pkg::REG_ATTRACT_Y, 12'd200);
    write_reg(pas_pkg::REG_ZOOM, 12'd4095);
    send_particle(24'sd25600, 24'sd51200, 16'sd300, -16'sd300);
    send_particle(24'sd25601, 24'sd51200, '0, '0);
    send_particle(24'sd25600, 24'sd51199, '0, '0);
    send_particle(24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF);
    send_particle(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000);
    send_particle(24'sh800000, 24'sh7FFFFF, 16'sh7FFF, 16'sh8000);
    send_particle('0, '0, 16'sh8000, 16'sh7FFF);
    start <= 1'b0;
    drain_pipeline();

    write_reg(pas_pkg::REG_ATTRACT_X, 12'd4095);
    write_reg(pas_pkg::REG_ATTRACT_Y, 12'd4095);
    write_reg(pas_pkg::REG_ZOOM, 12'd0);
    send_particle(24'sh0FFF00, 24'sh0FFF00, '0, '0);
    send_particle(24'sh0FFF01, 24'sh0FFF00, 16'sh7FFF, '0);
    send_particle(24'sh800000, 24'sh800000, '0, '0);
    start <= 1'b0;
    drain_pipeline();

    for (int phase = 0; phase < 8; phase++) begin
      ax = AW'($urandom);
      ay = AW'($urandom);
      write_reg(pas_pkg::REG_ENABLE, (phase % 4 == 3) ? 12'd0 : 12'($urandom));
      write_reg(pas_pkg::REG_ATTRACT_X, phase == 1 ? 12'd0 : ax);
      write_reg(pas_pkg::REG_ATTRACT_Y, phase == 1 ? 12'd0 : ay);
      write_reg(pas_pkg::REG_ZOOM, phase == 2 ? 12'd4095 : 12'($urandom_range(0, 4095)));
      if (phase == 1) begin
        ax = '0;
        ay = '0;
      end
      send_random(65, ax, ay);
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
